// ===== hw/rtl/tlnsf_pkg.sv =====
// Package for the text line number and squeeze filter.
// Holds the sizing constants, character codes, register indexes and the
// structs shared by the formatter, the output stage and the top level.
package tlnsf_pkg;

    localparam int DIGITS    = 6;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int MAX_RUN   = DIGITS + 3;
    localparam int IDX_W     = $clog2(MAX_RUN);
    localparam int CNT_W     = $clog2(MAX_RUN + 1);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOW_ENDS       = 2'd0,
        CFG_NUMBER_NONBLANK = 2'd1,
        CFG_NUMBER_ALL      = 2'd2,
        CFG_SQUEEZE_BLANK   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    typedef struct packed {
        logic show_ends;
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
    } cfg_t;

    // One input item's output bytes, byte 0 goes out first.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [CNT_W-1:0]        len;
    } run_t;

endpackage

// ===== hw/rtl/tlnsf_core.sv =====
// Line state and formatting logic of the text line filter.
// Turns one accepted input beat into the run of output bytes it causes.
// Depends on tlnsf_pkg.
module tlnsf_core
    import tlnsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] char_in,
    input  logic       stream_end,
    input  cfg_t       cfg,
    output run_t       run
);

    logic             at_start_reg, at_start_next;
    logic             prev_blank_reg, prev_blank_next;
    logic [BCD_W-1:0] count_reg, count_next;
    logic [BCD_W-1:0] count_inc;
    logic             do_num;
    logic             do_dollar;
    logic             has_final;
    logic [7:0]       final_byte;
    logic             leading;
    logic [CNT_W-1:0] pos;
    logic             is_nl;

    // Saturating packed-BCD increment: all nines stays all nines.
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             full;
        r     = v;
        carry = 1'b1;
        full  = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9)
            begin
                full = 1'b0;
            end
        end
        for (int i = 0; i < DIGITS; i++) begin
            if (carry)
            begin
                if (v[4*i +: 4] == 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        if (full)
        begin
            r = v;
        end
        return r;
    endfunction

    assign is_nl     = (char_in == CHAR_NL);
    assign count_inc = bcd_inc(count_reg);

    always_comb
    begin
        do_num          = 1'b0;
        do_dollar       = 1'b0;
        has_final       = 1'b0;
        final_byte      = char_in;
        at_start_next   = at_start_reg;
        prev_blank_next = prev_blank_reg;
        if (stream_end)
        begin
            do_dollar       = !at_start_reg && cfg.show_ends;
            at_start_next   = 1'b1;
            prev_blank_next = 1'b0;
        end
        else if (at_start_reg)
        begin
            if (is_nl)
            begin
                // A repeated empty line in squeeze mode leaves no trace.
                if (!(cfg.squeeze_blank && prev_blank_reg))
                begin
                    prev_blank_next = 1'b1;
                    do_num          = !cfg.number_nonblank && cfg.number_all;
                    do_dollar       = cfg.show_ends && !cfg.squeeze_blank;
                    has_final       = 1'b1;
                end
            end
            else
            begin
                prev_blank_next = 1'b0;
                do_num          = cfg.number_nonblank || cfg.number_all;
                has_final       = 1'b1;
                at_start_next   = 1'b0;
            end
        end
        else
        begin
            has_final = 1'b1;
            if (is_nl)
            begin
                do_dollar     = cfg.show_ends;
                at_start_next = 1'b1;
            end
        end

        if (stream_end)
        begin
            count_next = '0;
        end
        else if (do_num)
        begin
            count_next = count_inc;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Pack the number field, the end marker and the final byte into the run.
    always_comb
    begin
        run.bytes = '0;
        pos       = '0;
        leading   = 1'b1;
        if (do_num)
        begin
            for (int i = DIGITS - 1; i >= 0; i--) begin
                if ((count_inc[4*i +: 4] == 4'd0) && leading && (i > 0))
                begin
                    run.bytes[DIGITS-1-i] = CHAR_SPACE;
                end
                else
                begin
                    leading               = 1'b0;
                    run.bytes[DIGITS-1-i] = CHAR_ZERO + {4'd0, count_inc[4*i +: 4]};
                end
            end
            run.bytes[DIGITS] = CHAR_TAB;
            pos               = CNT_W'(DIGITS + 1);
        end
        if (do_dollar)
        begin
            run.bytes[pos[IDX_W-1:0]] = CHAR_DOLLAR;
            pos                       = pos + CNT_W'(1);
        end
        if (has_final)
        begin
            run.bytes[pos[IDX_W-1:0]] = final_byte;
            pos                       = pos + CNT_W'(1);
        end
        run.len = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg   <= 1'b1;
            prev_blank_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (in_fire)
        begin
            at_start_reg   <= at_start_next;
            prev_blank_reg <= prev_blank_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tlnsf_out.sv =====
// Output stage of the text line filter: holds one run of bytes and sends
// it one beat per cycle while out_ready is high, marking the run's last byte.
// Depends on tlnsf_pkg.
module tlnsf_out
    import tlnsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  run_t       run,
    output logic [7:0] char_out,
    output logic       out_valid,
    output logic       out_last,
    input  logic       out_ready,
    output logic       in_ready
);

    logic [MAX_RUN-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]        len_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic                    valid_reg;
    logic                    load_en;

    assign load_en   = load && (run.len != '0);
    assign char_out  = bytes_reg[pos_reg[IDX_W-1:0]];
    assign out_valid = valid_reg;
    assign out_last  = (pos_reg == (len_reg - CNT_W'(1)));
    // A new run may come in while the last byte of this one leaves.
    assign in_ready  = !valid_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (load_en)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            if (out_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            bytes_reg <= run.bytes;
            len_reg   <= run.len;
        end
    end

endmodule

// ===== hw/rtl/text_line_number_squeeze_filter_top.sv =====
// The first byte of an item's output is offered in the cycle after the beat is taken.
// Throughput: one input beat per cycle while each beat yields at most one byte and the output
// is ready; a beat that yields more bytes (up to DIGITS+3) holds the output until all have left,
// and the next input beat is taken in the cycle that the last of those bytes leaves.
// Reset: asynchronous, active low; all registers but the held output bytes and length clear, the
// line state starts at a line start, and the block takes beats as soon as reset is released.
module text_line_number_squeeze_filter_top
    import tlnsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_in
    input  logic                 s_axis_tuser,   // [0] stream_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] char_out
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cfg_t cfg_reg;
    run_t run;
    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SHOW_ENDS:       cfg_reg.show_ends       <= cfg_data;
                CFG_NUMBER_NONBLANK: cfg_reg.number_nonblank <= cfg_data;
                CFG_NUMBER_ALL:      cfg_reg.number_all      <= cfg_data;
                CFG_SQUEEZE_BLANK:   cfg_reg.squeeze_blank   <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tlnsf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .char_in    (s_axis_tdata),
        .stream_end (s_axis_tuser),
        .cfg        (cfg_reg),
        .run        (run)
    );

    tlnsf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .run       (run),
        .char_out  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready)
    );

    // An empty output stage always takes the next beat.
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    // With a run pending, input is taken only as its last byte leaves.
    a_ready_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast))
        else $error("input taken while a run is still pending");

    // A run does not end before its last byte.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("output run ended without a last byte");

endmodule
